// File: sv/tfn_pkg.sv
// Shared types and constants for the triangle face normal block.
`default_nettype none
package tfn_pkg;

	localparam int IDX_W      = 10;
	localparam int FIELD_W    = 24;
	localparam int NORM_W     = 16;
	localparam int IDX_EXT_W  = 17;
	localparam int LEAD_POS   = 29;
	localparam int QW         = 64;
	localparam int DW         = 48;
	localparam int QUO_STEPS  = 16;
	localparam int FRAC_SHIFT = 15;

	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_TRI  = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_READ,
		ST_CROSS,
		ST_ABS,
		ST_NORM,
		ST_SQUARE,
		ST_ROOT,
		ST_DIVLD,
		ST_DIV,
		ST_FINISH
	} state_t;

endpackage
`default_nettype wire

// File: sv/triangle_face_normal_top.sv
// Top level: vertex store plus iterative face normal datapath.
// Usage:
//   Input channel (in_valid / in_stall) carries either a vertex load
//   (mode 0: vertex_index, pos_x/y/z) or a triangle (mode 1: corner_a/b/c).
//   A load is written into the vertex store in its transfer cycle and
//   produces no result; the block is ready again on the next cycle.
//   A triangle produces exactly one result transfer on the output channel
//   (out_valid / out_stall): unit normal in Q1.14, the three corner indices
//   and the degenerate flag.
//   A triangle passes through the store reads, the cross product on the
//   shared multiplier, the magnitudes, the normalize shifts, the squares,
//   the one-bit-a-cycle square root, three restoring divides of one
//   quotient bit a cycle and the output load; a degenerate triangle skips
//   the squares, the root and the divides. in_stall is high for the whole
//   computation; the block takes the next item as early as the cycle in
//   which out_valid rises. The result sits in an output register; a new
//   item is accepted while it waits. If the receiver stalls, the next
//   finished result waits in the datapath until the output register
//   frees up.
//   Reset clears the control state and the output valid. The vertex store
//   is not cleared: a corner read from an entry never loaded is undefined.
//   Corner indices at or beyond VERTEX_DEPTH read position zero.
`default_nettype none
module triangle_face_normal_top
	import tfn_pkg::*;
#(
	parameter int VERTEX_DEPTH = 1024,
	parameter int POS_BITS     = 24
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic                     mode,
	input  logic [IDX_W-1:0]         vertex_index,
	input  logic signed [FIELD_W-1:0] pos_x,
	input  logic signed [FIELD_W-1:0] pos_y,
	input  logic signed [FIELD_W-1:0] pos_z,
	input  logic [IDX_W-1:0]         corner_a,
	input  logic [IDX_W-1:0]         corner_b,
	input  logic [IDX_W-1:0]         corner_c,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [NORM_W-1:0] normal_x,
	output logic signed [NORM_W-1:0] normal_y,
	output logic signed [NORM_W-1:0] normal_z,
	output logic [IDX_W-1:0]         out_corner_a,
	output logic [IDX_W-1:0]         out_corner_b,
	output logic [IDX_W-1:0]         out_corner_c,
	output logic                     degenerate
);

	localparam int AW  = (VERTEX_DEPTH > 1) ? $clog2(VERTEX_DEPTH) : 1;
	localparam int EW  = POS_BITS + 1;           // edge vector width
	localparam int CW  = 2 * POS_BITS + 3;       // cross product width
	localparam int OPW = (EW > 31) ? EW : 31;    // multiplier operand width
	localparam int PW  = 2 * OPW;
	localparam int NW  = (CW > 40) ? CW : 40;    // normalize shifter width

	state_t state_q, state_d;
	logic [4:0] cnt_q, cnt_d;
	logic [1:0] comp_q;

	logic in_fire;
	assign in_fire = in_valid & ~in_stall;

	// ---------------- vertex store: one write port, one read port
	logic [3*POS_BITS-1:0] mem [VERTEX_DEPTH];
	logic [3*POS_BITS-1:0] rd_data_q;
	logic                  rd_ok_q;
	logic [IDX_EXT_W-1:0]  wr_idx, rd_idx;
	logic [IDX_W-1:0]      rd_sel;
	logic                  wr_en;
	logic [3*POS_BITS-1:0] wr_data;
	logic [IDX_W-1:0]      ca_q, cb_q, cc_q;

	assign wr_idx  = IDX_EXT_W'(vertex_index);
	assign wr_en   = in_fire & (mode == MODE_LOAD) & (wr_idx < IDX_EXT_W'(VERTEX_DEPTH));
	assign wr_data = {POS_BITS'(32'(pos_z)), POS_BITS'(32'(pos_y)), POS_BITS'(32'(pos_x))};

	always_comb begin
		case (cnt_q[1:0])
			2'd0:    rd_sel = ca_q;
			2'd1:    rd_sel = cb_q;
			default: rd_sel = cc_q;
		endcase
	end
	assign rd_idx = IDX_EXT_W'(rd_sel);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx[AW-1:0]] <= wr_data;
		end
		rd_data_q <= mem[rd_idx[AW-1:0]];
		rd_ok_q   <= rd_idx < IDX_EXT_W'(VERTEX_DEPTH);
	end

	logic signed [POS_BITS-1:0] rd_x, rd_y, rd_z;
	assign rd_x = rd_ok_q ? rd_data_q[POS_BITS-1:0] : '0;
	assign rd_y = rd_ok_q ? rd_data_q[2*POS_BITS-1:POS_BITS] : '0;
	assign rd_z = rd_ok_q ? rd_data_q[3*POS_BITS-1:2*POS_BITS] : '0;

	// ---------------- datapath registers
	logic signed [POS_BITS-1:0] a_x_q, a_y_q, a_z_q;
	logic signed [EW-1:0] e1x_q, e1y_q, e1z_q, e2x_q, e2y_q, e2z_q;
	logic signed [CW-1:0] crx_q, cry_q, crz_q;
	logic [NW-1:0] mg0_q, mg1_q, mg2_q;
	logic [2:0]    neg_q;
	logic [QW-1:0] q_q, res_q, bit_q;
	logic [DW-1:0] rem_q, dsh_q;
	logic [NORM_W-1:0] quo_q;
	logic signed [NORM_W-1:0] nx_q, ny_q, nz_q;
	logic degen_q;

	// shared multiplier, registered product
	logic signed [OPW-1:0] mul_a, mul_b;
	logic signed [PW-1:0]  prod_q;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		if (state_q == ST_CROSS) begin
			case (cnt_q[2:0])
				3'd0:    begin mul_a = OPW'(e1y_q); mul_b = OPW'(e2z_q); end
				3'd1:    begin mul_a = OPW'(e1z_q); mul_b = OPW'(e2y_q); end
				3'd2:    begin mul_a = OPW'(e1z_q); mul_b = OPW'(e2x_q); end
				3'd3:    begin mul_a = OPW'(e1x_q); mul_b = OPW'(e2z_q); end
				3'd4:    begin mul_a = OPW'(e1x_q); mul_b = OPW'(e2y_q); end
				3'd5:    begin mul_a = OPW'(e1y_q); mul_b = OPW'(e2x_q); end
				default: ;
			endcase
		end else begin
			case (cnt_q[1:0])
				2'd0:    begin
					mul_a = $signed(OPW'({1'b0, mg0_q[LEAD_POS:0]}));
					mul_b = mul_a;
				end
				2'd1:    begin
					mul_a = $signed(OPW'({1'b0, mg1_q[LEAD_POS:0]}));
					mul_b = mul_a;
				end
				default: begin
					mul_a = $signed(OPW'({1'b0, mg2_q[LEAD_POS:0]}));
					mul_b = mul_a;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	// magnitudes of the cross product
	logic [CW-1:0] abs_x, abs_y, abs_z;
	assign abs_x = crx_q[CW-1] ? (~crx_q + 1'b1) : crx_q;
	assign abs_y = cry_q[CW-1] ? (~cry_q + 1'b1) : cry_q;
	assign abs_z = crz_q[CW-1] ? (~crz_q + 1'b1) : crz_q;

	// normalize decisions on the OR of the magnitudes (same leading one as max)
	logic [NW-1:0] orv;
	logic is_zero, big8, big1, small8, small1;
	assign orv     = mg0_q | mg1_q | mg2_q;
	assign is_zero = (orv == '0);
	assign big8    = |orv[NW-1:LEAD_POS+9];
	assign big1    = |orv[NW-1:LEAD_POS+1];
	assign small8  = ~|orv[NW-1:LEAD_POS-8];
	assign small1  = ~orv[LEAD_POS];

	// square root step
	logic [QW-1:0] root_t;
	assign root_t = res_q + bit_q;

	// divider step
	logic              div_ge;
	logic [DW-1:0]     rem_nx;
	logic [NORM_W-1:0] quo_nx;
	logic [LEAD_POS:0] a_sel;
	logic              neg_sel;
	logic signed [NORM_W-1:0] n_signed;
	assign div_ge   = rem_q >= dsh_q;
	assign rem_nx   = div_ge ? (rem_q - dsh_q) : rem_q;
	assign quo_nx   = {quo_q[NORM_W-2:0], div_ge};
	assign n_signed = neg_sel ? $signed(~quo_nx + 1'b1) : $signed(quo_nx);

	always_comb begin
		case (comp_q)
			2'd0:    begin a_sel = mg0_q[LEAD_POS:0]; neg_sel = neg_q[0]; end
			2'd1:    begin a_sel = mg1_q[LEAD_POS:0]; neg_sel = neg_q[1]; end
			default: begin a_sel = mg2_q[LEAD_POS:0]; neg_sel = neg_q[2]; end
		endcase
	end

	logic out_load;

	// ---------------- sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q + 1'b1;
		in_stall = 1'b1;
		out_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				cnt_d    = '0;
				if (in_fire && mode == MODE_TRI) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				if (cnt_q == 5'd3) begin
					state_d = ST_CROSS;
					cnt_d   = '0;
				end
			end
			ST_CROSS: begin
				if (cnt_q == 5'd6) begin
					state_d = ST_ABS;
				end
			end
			ST_ABS: begin
				state_d = ST_NORM;
				cnt_d   = '0;
			end
			ST_NORM: begin
				cnt_d = '0;
				if (is_zero) begin
					state_d = ST_FINISH;
				end else if (!big1 && !small1) begin
					state_d = ST_SQUARE;
				end
			end
			ST_SQUARE: begin
				if (cnt_q == 5'd3) begin
					state_d = ST_ROOT;
				end
			end
			ST_ROOT: begin
				if (bit_q == '0) begin
					state_d = ST_DIVLD;
				end
			end
			ST_DIVLD: begin
				state_d = ST_DIV;
				cnt_d   = '0;
			end
			ST_DIV: begin
				if (cnt_q == 5'(QUO_STEPS - 1)) begin
					state_d = (comp_q == 2'd2) ? ST_FINISH : ST_DIVLD;
				end
			end
			ST_FINISH: begin
				if (!out_valid || !out_stall) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// ---------------- datapath updates
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					ca_q    <= corner_a;
					cb_q    <= corner_b;
					cc_q    <= corner_c;
					degen_q <= 1'b0;
					nx_q    <= '0;
					ny_q    <= '0;
					nz_q    <= '0;
					comp_q  <= '0;
				end
			end
			ST_READ: begin
				case (cnt_q[1:0])
					2'd1: begin
						a_x_q <= rd_x;
						a_y_q <= rd_y;
						a_z_q <= rd_z;
					end
					2'd2: begin
						e1x_q <= EW'(rd_x) - EW'(a_x_q);
						e1y_q <= EW'(rd_y) - EW'(a_y_q);
						e1z_q <= EW'(rd_z) - EW'(a_z_q);
					end
					2'd3: begin
						e2x_q <= EW'(rd_x) - EW'(a_x_q);
						e2y_q <= EW'(rd_y) - EW'(a_y_q);
						e2z_q <= EW'(rd_z) - EW'(a_z_q);
					end
					default: ;
				endcase
			end
			ST_CROSS: begin
				// registered product of step k lands in the next cycle
				case (cnt_q[2:0])
					3'd1: crx_q <= CW'(prod_q);
					3'd2: crx_q <= crx_q - CW'(prod_q);
					3'd3: cry_q <= CW'(prod_q);
					3'd4: cry_q <= cry_q - CW'(prod_q);
					3'd5: crz_q <= CW'(prod_q);
					3'd6: crz_q <= crz_q - CW'(prod_q);
					default: ;
				endcase
			end
			ST_ABS: begin
				mg0_q <= NW'(abs_x);
				mg1_q <= NW'(abs_y);
				mg2_q <= NW'(abs_z);
				neg_q <= {crz_q[CW-1], cry_q[CW-1], crx_q[CW-1]};
			end
			ST_NORM: begin
				if (is_zero) begin
					degen_q <= 1'b1;
				end else if (big8) begin
					mg0_q <= mg0_q >> 8;
					mg1_q <= mg1_q >> 8;
					mg2_q <= mg2_q >> 8;
				end else if (big1) begin
					mg0_q <= mg0_q >> 1;
					mg1_q <= mg1_q >> 1;
					mg2_q <= mg2_q >> 1;
				end else if (small8) begin
					mg0_q <= mg0_q << 8;
					mg1_q <= mg1_q << 8;
					mg2_q <= mg2_q << 8;
				end else if (small1) begin
					mg0_q <= mg0_q << 1;
					mg1_q <= mg1_q << 1;
					mg2_q <= mg2_q << 1;
				end
			end
			ST_SQUARE: begin
				case (cnt_q[1:0])
					2'd1: q_q <= QW'(unsigned'(prod_q));
					2'd2: q_q <= q_q + QW'(unsigned'(prod_q));
					2'd3: begin
						q_q   <= q_q + QW'(unsigned'(prod_q));
						res_q <= '0;
						bit_q <= QW'(1) << (QW - 2);
					end
					default: ;
				endcase
			end
			ST_ROOT: begin
				if (bit_q != '0) begin
					if (q_q >= root_t) begin
						q_q   <= q_q - root_t;
						res_q <= (res_q >> 1) + bit_q;
					end else begin
						res_q <= res_q >> 1;
					end
					bit_q <= bit_q >> 2;
				end
			end
			ST_DIVLD: begin
				// n = floor((a * 2^15 + r) / (2r)), one quotient bit a cycle
				rem_q <= (DW'(a_sel) << FRAC_SHIFT) + DW'(res_q[31:0]);
				dsh_q <= DW'(res_q[31:0]) << QUO_STEPS;
				quo_q <= '0;
			end
			ST_DIV: begin
				rem_q <= rem_nx;
				dsh_q <= dsh_q >> 1;
				quo_q <= quo_nx;
				if (cnt_q == 5'(QUO_STEPS - 1)) begin
					case (comp_q)
						2'd0:    nx_q <= n_signed;
						2'd1:    ny_q <= n_signed;
						default: nz_q <= n_signed;
					endcase
					comp_q <= comp_q + 1'b1;
				end
			end
			default: ;
		endcase
	end

	// ---------------- output register
	logic out_valid_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			normal_x     <= nx_q;
			normal_y     <= ny_q;
			normal_z     <= nz_q;
			out_corner_a <= ca_q;
			out_corner_b <= cb_q;
			out_corner_c <= cc_q;
			degenerate   <= degen_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

// File: sv/tfn_checker.sv
// Port-level checker for the triangle face normal block, with its bind.
`default_nettype none
module tfn_checker
	import tfn_pkg::*;
(
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_stall,
	input logic                      mode,
	input logic                      out_valid,
	input logic                      out_stall,
	input logic signed [NORM_W-1:0]  normal_x,
	input logic signed [NORM_W-1:0]  normal_y,
	input logic signed [NORM_W-1:0]  normal_z,
	input logic                      degenerate
);

	// a load never blocks the next transfer
	a_load_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && mode == MODE_LOAD) |=> !in_stall)
		else $error("stall after vertex load");

	// a triangle occupies the datapath
	a_tri_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && mode == MODE_TRI) |=> in_stall)
		else $error("ready right after triangle transfer");

	// a result cannot show up in the cycle right after an input transfer
	a_no_instant: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> !$rose(out_valid))
		else $error("result too early");

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && degenerate) |-> (normal_x == 0 && normal_y == 0 && normal_z == 0))
		else $error("degenerate result with nonzero normal");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(normal_x) && $stable(degenerate)))
		else $error("stalled result changed");

endmodule

bind triangle_face_normal_top tfn_checker u_tfn_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.mode       (mode),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.normal_x   (normal_x),
	.normal_y   (normal_y),
	.normal_z   (normal_z),
	.degenerate (degenerate)
);
`default_nettype wire
